// ===== design/sbl_pkg.sv =====
// Shared types, constants and step table lookup for the stepped backlight controller.
package sbl_pkg;

    localparam int STEP_COUNT = 17;
    localparam int TABLE_LEN  = 17;
    localparam int STEP_IDX_W = $clog2(STEP_COUNT);

    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    localparam logic [15:0] ON_DELAY_RST  = 16'd300;
    localparam logic [15:0] OFF_DELAY_RST = 16'd60;
    localparam logic [7:0]  BOOT_LVL_RST  = 8'd0;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_SET    = 3'd1,
        CMD_SILENT = 3'd2,
        CMD_RESTORE = 3'd3,
        CMD_UP     = 3'd4,
        CMD_DOWN   = 3'd5,
        CMD_ON     = 3'd6,
        CMD_OFF    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_ON_DELAY  = 2'd0,
        CFG_OFF_DELAY = 2'd1,
        CFG_BOOT_LVL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] level;
    } t_in;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       enable;
        logic       is_on;
        logic [7:0] current_level;
        logic       persist_write;
        logic       busy_res;
    } t_out;

    // Brightness steps; positions past the listed entries read as full scale.
    function automatic logic [7:0] table_at(input int idx);
        logic [7:0] val;
        case (idx)
            0:  val = 8'd0;
            1:  val = 8'd1;
            2:  val = 8'd2;
            3:  val = 8'd3;
            4:  val = 8'd4;
            5:  val = 8'd6;
            6:  val = 8'd8;
            7:  val = 8'd12;
            8:  val = 8'd16;
            9:  val = 8'd23;
            10: val = 8'd32;
            11: val = 8'd45;
            12: val = 8'd64;
            13: val = 8'd90;
            14: val = 8'd128;
            15: val = 8'd180;
            16: val = 8'd255;
            default: val = LEVEL_MAX;
        endcase
        return val;
    endfunction

    // Step whose interval holds lv, top step above 180; parallel compares, lowest match wins.
    function automatic logic [STEP_IDX_W-1:0] nearest_step(input logic [7:0] lv);
        logic [STEP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = STEP_COUNT - 2; i >= 0; i--) begin
            if (table_at(i) <= lv && table_at(i + 1) > lv) begin
                idx = STEP_IDX_W'(i);
            end
        end
        if (lv > table_at(STEP_COUNT - 2)) begin
            idx = STEP_IDX_W'(STEP_COUNT - 1);
        end
        return idx;
    endfunction

endpackage

// ===== design/stepped_backlight_controller.sv =====
// Top level of the stepped backlight controller: command decode, power sequencing, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | request   | i_in_valid / o_in_ready | i_in  (cmd, level)
//  out     | result    | o_out_valid/i_out_ready | o_out (duty, enable, on, level,
//          |           |                         |        persist, busy)
//  cfg     | write     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while the output is not stalled; its result is registered and appears the next cycle.
// State updates at acceptance through one level of compare/select logic.
// The result register accepts a new request while its contents are being taken;
// a stalled output holds off input only while that register is full.
// Synchronous active-low reset loads the register defaults and saved level.
module stepped_backlight_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sbl_pkg::t_in        i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sbl_pkg::t_out       o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import sbl_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ON_WAIT  = 2'd1,
        PH_OFF_WAIT = 2'd2
    } t_phase;

    logic [15:0] r_on_delay;
    logic [15:0] r_off_delay;

    logic [7:0]  r_level,  n_level;
    logic        r_on,     n_on;
    logic [7:0]  r_saved,  n_saved;
    logic [7:0]  r_duty,   n_duty;
    logic        r_enable, n_enable;
    t_phase      r_phase,  n_phase;
    logic [15:0] r_delay,  n_delay;
    logic        n_persist;
    logic        n_busy;

    logic        r_out_valid;
    t_out        r_out;

    logic        in_acc;
    logic        cfg_acc;
    logic        apply;
    logic        drive;
    logic [7:0]  apply_lvl;
    logic [STEP_IDX_W-1:0] cur_step;
    logic [7:0]  up_lvl;
    logic [7:0]  down_lvl;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cur_step = nearest_step(r_level);
    assign up_lvl   = table_at(int'(cur_step) + 1);
    assign down_lvl = table_at(int'(cur_step) - 1);

    always_comb begin
        n_level   = r_level;
        n_on      = r_on;
        n_saved   = r_saved;
        n_duty    = r_duty;
        n_enable  = r_enable;
        n_phase   = r_phase;
        n_delay   = r_delay;
        n_persist = 1'b0;
        n_busy    = 1'b0;
        apply     = 1'b0;
        drive     = 1'b1;
        apply_lvl = i_in.level;

        if (r_phase != PH_IDLE) begin
            if (i_in.cmd == CMD_TICK) begin
                if (r_delay <= 16'd1) begin
                    if (r_phase == PH_ON_WAIT) begin
                        n_duty = r_level;
                    end else begin
                        n_enable = 1'b0;
                    end
                    n_phase = PH_IDLE;
                    n_delay = '0;
                end else begin
                    n_delay = r_delay - 16'd1;
                end
            end else begin
                n_busy = 1'b1;
            end
        end else begin
            case (i_in.cmd)
                CMD_SET: begin
                    apply = 1'b1;
                end
                CMD_SILENT: begin
                    apply = 1'b1;
                    drive = 1'b0;
                end
                CMD_RESTORE: begin
                    apply     = 1'b1;
                    apply_lvl = (r_saved == 8'd0) ? LEVEL_MAX : r_saved;
                end
                CMD_UP: begin
                    apply     = r_on && (cur_step != STEP_IDX_W'(STEP_COUNT - 1));
                    apply_lvl = up_lvl;
                end
                CMD_DOWN: begin
                    apply     = r_on && (cur_step != '0);
                    apply_lvl = down_lvl;
                end
                CMD_ON: begin
                    n_on     = 1'b1;
                    n_enable = 1'b1;
                    if (r_on_delay == 16'd0) begin
                        // zero delay: restore finishes within this request
                        n_duty = r_level;
                    end else begin
                        n_duty  = 8'd0;
                        n_phase = PH_ON_WAIT;
                        n_delay = r_on_delay;
                    end
                end
                CMD_OFF: begin
                    n_on   = 1'b0;
                    n_duty = 8'd0;
                    if (r_off_delay == 16'd0) begin
                        n_enable = 1'b0;
                    end else begin
                        n_phase = PH_OFF_WAIT;
                        n_delay = r_off_delay;
                    end
                end
                default: begin
                end
            endcase

            if (apply) begin
                n_level   = apply_lvl;
                n_saved   = apply_lvl;
                n_persist = 1'b1;
                if (drive && r_on) begin
                    n_duty = apply_lvl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_delay  <= ON_DELAY_RST;
            r_off_delay <= OFF_DELAY_RST;
            r_level     <= '0;
            r_on        <= 1'b0;
            r_saved     <= BOOT_LVL_RST;
            r_duty      <= '0;
            r_enable    <= 1'b0;
            r_phase     <= PH_IDLE;
            r_delay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_level  <= n_level;
                r_on     <= n_on;
                r_saved  <= n_saved;
                r_duty   <= n_duty;
                r_enable <= n_enable;
                r_phase  <= n_phase;
                r_delay  <= n_delay;
                r_out    <= '{pwm_duty: n_duty, enable: n_enable, is_on: n_on,
                              current_level: n_level, persist_write: n_persist,
                              busy_res: n_busy};
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_ON_DELAY: begin
                        r_on_delay <= i_cfg_data;
                    end
                    CFG_OFF_DELAY: begin
                        r_off_delay <= i_cfg_data;
                    end
                    CFG_BOOT_LVL: begin
                        // boot load: saved level follows the persisted value
                        r_saved <= i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
